>>> rtl/core/dlci_pkg.sv
// Package for the edge rasterizer with color interpolation.
// Fixed field widths, action codes and payload types shared by the
// channel interfaces and the core. No dependencies.
package dlci_pkg;

    // Fixed widths of the configuration register and the result fields
    localparam int PITCH_W     = 13;
    localparam int PIX_ADDR_W  = 24;
    localparam int PIX_COLOR_W = 24;

    // Row pitch after reset
    localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd1024;

    // Action codes of an input transaction
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    typedef logic [PITCH_W-1:0]     pitch_t;
    typedef logic [PIX_ADDR_W-1:0]  pix_addr_t;
    typedef logic [PIX_COLOR_W-1:0] pix_color_t;

endpackage

>>> rtl/core/dlci_if.sv
// Channel interfaces of the edge rasterizer: configuration write,
// request (load or step) and pixel result.
// Depends on dlci_pkg.

interface dlci_cfg_if
    import dlci_pkg::*;
();
    logic   valid;
    logic   ready;
    pitch_t row_pitch;

    modport source (output valid, output row_pitch, input ready);
    modport sink   (input valid, input row_pitch, output ready);
endinterface

interface dlci_req_if #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
);
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COLOR_BITS-1:0] start_color;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] end_color;

    modport source (output valid, output action, output start_x, output start_y,
                    output start_color, output end_x, output end_y, output end_color,
                    input ready);
    modport sink   (input valid, input action, input start_x, input start_y,
                    input start_color, input end_x, input end_y, input end_color,
                    output ready);
endinterface

interface dlci_rsp_if
    import dlci_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       pixel_valid;
    pix_addr_t  pixel_address;
    pix_color_t pixel_color;
    logic       last_pixel;

    modport source (output valid, output pixel_valid, output pixel_address,
                    output pixel_color, output last_pixel, input ready);
    modport sink   (input valid, input pixel_valid, input pixel_address,
                    input pixel_color, input last_pixel, output ready);
endinterface

>>> rtl/core/dda_line_color_interpolator_top.sv
// Edge rasterizer with linear color interpolation: top level and core.
// Depends on dlci_pkg and the channel interfaces in dlci_if.sv.
//
// A load transaction latches an edge, and its all-zero result goes from the
// emit state into the output register; a step while no edge is active
// does the same. A step on an active edge returns the next interior pixel:
// x, y and color each need one rounded division by the span count, and all
// three go through one shared restoring divider that retires one quotient
// bit per cycle, fed by one shared multiplier that also forms row_pitch*y.
// One transaction is in work at a time; the request side is ready only
// while the sequencer is idle, so a new request is taken in the cycle after
// the previous result is handed over. A result waiting in the output
// register does not hold off the next request, but that request's own
// result waits in the sequencer until the register frees, which adds every
// stalled cycle on rsp to its time.
// The row pitch may be written at any time the block is idle.
module dda_line_color_interpolator_top
    import dlci_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    dlci_cfg_if.sink  cfg,
    dlci_req_if.sink  req,
    dlci_rsp_if.source rsp
);

    localparam int CW   = COORD_BITS;
    localparam int KW   = COLOR_BITS;
    localparam int QW   = (KW > CW) ? KW : CW;
    localparam int MA   = (QW > PITCH_W) ? QW : PITCH_W;
    localparam int PW   = MA + CW;
    localparam int DW   = PW + 2;
    localparam int RW   = CW + 2;
    localparam int CNTW = $clog2(QW + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DINIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ADDR  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // Quantity under division
    localparam logic [1:0] PH_X = 2'd0;
    localparam logic [1:0] PH_Y = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    phase_reg;
    pitch_t        pitch_reg;

    // Edge state
    logic [CW-1:0] origin_x_reg, origin_y_reg;
    logic [KW-1:0] origin_color_reg;
    logic [CW-1:0] mag_x_reg, mag_y_reg;
    logic [KW-1:0] mag_c_reg;
    logic          neg_x_reg, neg_y_reg, neg_c_reg;
    logic [CW-1:0] span_reg;
    logic [CW-1:0] step_reg;
    logic          active_reg;

    // Per-transaction work registers
    logic          pix_flag_reg;
    logic          last_flag_reg;
    logic [PW-1:0] prod_reg;
    logic [RW-1:0] rem_reg;
    logic [QW-1:0] sh_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CW-1:0] x_res_reg, y_res_reg;
    logic [KW-1:0] c_res_reg;

    // Output register
    logic          out_valid_reg;
    logic          pixel_valid_reg;
    pix_addr_t     address_reg;
    pix_color_t    color_reg;
    logic          last_reg;

    // Handshakes
    logic req_go, out_go;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_go    = req.valid && req.ready;
    assign out_go    = !out_valid_reg || rsp.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.pixel_valid   = pixel_valid_reg;
    assign rsp.pixel_address = address_reg;
    assign rsp.pixel_color   = color_reg;
    assign rsp.last_pixel    = last_reg;

    // Edge setup from a load transaction
    logic          ld_neg_x, ld_neg_y, ld_neg_c;
    logic [CW-1:0] ld_mag_x, ld_mag_y, ld_span;
    logic [KW-1:0] ld_mag_c;
    always_comb
    begin
        ld_neg_x = req.end_x < req.start_x;
        ld_neg_y = req.end_y < req.start_y;
        ld_neg_c = req.end_color < req.start_color;
        ld_mag_x = ld_neg_x ? req.start_x - req.end_x : req.end_x - req.start_x;
        ld_mag_y = ld_neg_y ? req.start_y - req.end_y : req.end_y - req.start_y;
        ld_mag_c = ld_neg_c ? req.start_color - req.end_color
                            : req.end_color - req.start_color;
        ld_span  = (ld_mag_x > ld_mag_y) ? ld_mag_x : ld_mag_y;
    end

    // Last interior pixel when the next index reaches the span
    logic [CW:0] step_inc;
    assign step_inc = {1'b0, step_reg} + (CW+1)'(1);

    // Shared multiplier: |delta| * i during divisions, pitch * y for the address
    logic [MA-1:0] mul_a;
    logic [CW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic          cur_neg;
    always_comb
    begin
        case (phase_reg)
            PH_X:    begin mul_a = MA'(mag_x_reg); cur_neg = neg_x_reg; end
            PH_Y:    begin mul_a = MA'(mag_y_reg); cur_neg = neg_y_reg; end
            default: begin mul_a = MA'(mag_c_reg); cur_neg = neg_c_reg; end
        endcase
        mul_b = step_reg;
        if (state_reg == S_ADDR)
        begin
            mul_a = MA'(pitch_reg);
            mul_b = y_res_reg;
        end
        mul_p = mul_a * mul_b;
    end

    // Rounded dividend 2*|q| + n, less one when rounding toward the smaller end
    logic [DW-1:0] dvd;
    logic [RW-1:0] div_w;
    logic [RW-1:0] trial;
    logic          trial_ge;
    always_comb
    begin
        dvd      = DW'({prod_reg, 1'b0}) + DW'(span_reg) - DW'(cur_neg);
        div_w    = RW'({span_reg, 1'b0});
        trial    = {rem_reg[RW-2:0], sh_reg[QW-1]};
        trial_ge = trial >= div_w;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_go)
                    state_next = (req.action == ACTION_STEP && active_reg) ? S_MUL : S_EMIT;
            end
            S_MUL:   state_next = S_DINIT;
            S_DINIT: state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = (phase_reg == PH_C) ? S_ADDR : S_MUL;
            end
            S_ADDR:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_go)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and edge state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_X;
            pitch_reg        <= PITCH_RESET;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            origin_color_reg <= '0;
            mag_x_reg        <= '0;
            mag_y_reg        <= '0;
            mag_c_reg        <= '0;
            neg_x_reg        <= 1'b0;
            neg_y_reg        <= 1'b0;
            neg_c_reg        <= 1'b0;
            span_reg         <= '0;
            step_reg         <= '0;
            active_reg       <= 1'b0;
            pix_flag_reg     <= 1'b0;
            last_flag_reg    <= 1'b0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Take a new row pitch
            if (cfg.valid && cfg.ready)
                pitch_reg <= cfg.row_pitch;

            // Latch an edge or start a step
            if (req_go)
            begin
                pix_flag_reg  <= 1'b0;
                last_flag_reg <= step_inc == {1'b0, span_reg};
                phase_reg     <= PH_X;
                if (req.action == ACTION_LOAD)
                begin
                    origin_x_reg     <= req.start_x;
                    origin_y_reg     <= req.start_y;
                    origin_color_reg <= req.start_color;
                    mag_x_reg        <= ld_mag_x;
                    mag_y_reg        <= ld_mag_y;
                    mag_c_reg        <= ld_mag_c;
                    neg_x_reg        <= ld_neg_x;
                    neg_y_reg        <= ld_neg_y;
                    neg_c_reg        <= ld_neg_c;
                    span_reg         <= ld_span;
                    step_reg         <= CW'(1);
                    active_reg       <= ld_span >= CW'(2);
                end
                else if (active_reg)
                begin
                    pix_flag_reg <= 1'b1;
                end
            end

            // Load the bit counter for this division
            if (state_reg == S_DINIT)
                cnt_reg <= (phase_reg == PH_C) ? CNTW'(KW) : CNTW'(CW);

            // Count quotient bits, then advance to the next quantity
            if (state_reg == S_DIV)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - CNTW'(1);
                else if (phase_reg == PH_X)
                    phase_reg <= PH_Y;
                else if (phase_reg == PH_Y)
                    phase_reg <= PH_C;
            end

            // Hand the result to the output register and advance the edge
            if (state_reg == S_EMIT && out_go)
            begin
                out_valid_reg <= 1'b1;
                if (pix_flag_reg)
                begin
                    step_reg <= step_inc[CW-1:0];
                    if (last_flag_reg)
                        active_reg <= 1'b0;
                end
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL || state_reg == S_ADDR)
            prod_reg <= mul_p;

        // Split the dividend: high part seeds the remainder, low part is shifted in
        if (state_reg == S_DINIT)
        begin
            if (phase_reg == PH_C)
            begin
                rem_reg <= RW'(dvd >> KW);
                sh_reg  <= QW'(dvd[KW-1:0]) << (QW - KW);
            end
            else
            begin
                rem_reg <= RW'(dvd >> CW);
                sh_reg  <= QW'(dvd[CW-1:0]) << (QW - CW);
            end
        end

        // One restoring step a cycle, then apply the rounded offset
        if (state_reg == S_DIV)
        begin
            if (cnt_reg != '0)
            begin
                rem_reg <= trial_ge ? trial - div_w : trial;
                sh_reg  <= {sh_reg[QW-2:0], trial_ge};
            end
            else
            begin
                case (phase_reg)
                    PH_X:
                        x_res_reg <= cur_neg ? origin_x_reg - sh_reg[CW-1:0]
                                             : origin_x_reg + sh_reg[CW-1:0];
                    PH_Y:
                        y_res_reg <= cur_neg ? origin_y_reg - sh_reg[CW-1:0]
                                             : origin_y_reg + sh_reg[CW-1:0];
                    default:
                        c_res_reg <= cur_neg ? origin_color_reg - sh_reg[KW-1:0]
                                             : origin_color_reg + sh_reg[KW-1:0];
                endcase
            end
        end

        // Output payload
        if (state_reg == S_EMIT && out_go)
        begin
            pixel_valid_reg <= pix_flag_reg;
            last_reg        <= pix_flag_reg && last_flag_reg;
            address_reg     <= pix_flag_reg
                             ? PIX_ADDR_W'(prod_reg) + PIX_ADDR_W'(x_res_reg)
                             : '0;
            color_reg       <= pix_flag_reg ? PIX_COLOR_W'(c_res_reg) : '0;
        end
    end

    // An active edge always has interior pixels left
    a_active_span: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (span_reg >= CW'(2)) && (step_reg < span_reg))
        else $error("active edge with no interior pixel left");

    // The partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < div_w))
        else $error("divider remainder out of range");

    // Emitting the final pixel retires the edge
    a_last_retire: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_go && pix_flag_reg && last_flag_reg) |=> !active_reg)
        else $error("edge still active after its last pixel");

    // A step result is produced only for an edge that was active
    a_pix_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (active_reg && pix_flag_reg))
        else $error("pixel computation without an active edge");

endmodule

>>> tb/sv/testbench.sv
// Testbench for the edge rasterizer with color interpolation.
// It drives load and step requests, predicts each pixel result and checks it.
// Depends on dlci_pkg, the channel interfaces and dda_line_color_interpolator_top.
module testbench;
    import dlci_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int COLOR_BITS  = 24;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 60;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef struct packed {
        logic   action;
        coord_t start_x;
        coord_t start_y;
        color_t start_color;
        coord_t end_x;
        coord_t end_y;
        color_t end_color;
    } line_req_t;

    typedef struct packed {
        logic       pixel_valid;
        pix_addr_t  pixel_address;
        pix_color_t pixel_color;
        logic       last_pixel;
    } pixel_t;

    // Tracks the latched edge and the pixels still owed by the block
    class pixel_predictor;
        pitch_t    row_pitch;
        longint    origin_x;
        longint    origin_y;
        longint    origin_color;
        longint    delta_x;
        longint    delta_y;
        longint    delta_color;
        longint    span_len;
        longint    step_idx;
        bit        line_active;
        pixel_t    expected_pixels[$];
        int        error_count;

        function new();
            row_pitch    = PITCH_RESET;
            origin_x     = 0;
            origin_y     = 0;
            origin_color = 0;
            delta_x      = 0;
            delta_y      = 0;
            delta_color  = 0;
            span_len     = 0;
            step_idx     = 0;
            line_active  = 1'b0;
            error_count  = 0;
        endfunction

        // round(base + delta*i/n), half away from zero; never negative here
        function longint round_interp(longint base, longint delta, longint i, longint n);
            longint num;
            num = base * n + delta * i;
            return (2 * num + n) / (2 * n);
        endfunction

        // Update the edge state for one accepted request and queue its result
        function void note_request(line_req_t r);
            pixel_t p;
            longint adx;
            longint ady;
            longint x;
            longint y;
            longint c;
            longint addr;
            p = '0;
            if (r.action == ACTION_LOAD) begin
                origin_x     = longint'(r.start_x);
                origin_y     = longint'(r.start_y);
                origin_color = longint'(r.start_color);
                delta_x      = longint'(r.end_x) - origin_x;
                delta_y      = longint'(r.end_y) - origin_y;
                delta_color  = longint'(r.end_color) - origin_color;
                adx          = (delta_x < 0) ? -delta_x : delta_x;
                ady          = (delta_y < 0) ? -delta_y : delta_y;
                span_len     = (adx > ady) ? adx : ady;
                step_idx     = 1;
                line_active  = (span_len >= 2);
            end
            else if (line_active) begin
                x = round_interp(origin_x, delta_x, step_idx, span_len);
                y = round_interp(origin_y, delta_y, step_idx, span_len);
                c = (delta_color == 0) ? origin_color
                                       : round_interp(origin_color, delta_color,
                                                      step_idx, span_len);
                addr = longint'(row_pitch) * y + x;
                p.pixel_valid   = 1'b1;
                p.pixel_address = pix_addr_t'(addr);
                p.pixel_color   = pix_color_t'(c);
                p.last_pixel    = (step_idx + 1 == span_len);
                if (p.last_pixel)
                    line_active = 1'b0;
                step_idx = (step_idx + 1) & COORD_MAX;
            end
            expected_pixels.push_back(p);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel result: address %0h, color %0h",
                       got.pixel_address, got.pixel_color);
                error_count++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_valid !== want.pixel_valid) begin
                $error("pixel_valid: expected %0b, actual %0b", want.pixel_valid,
                       got.pixel_valid);
                error_count++;
            end
            if (got.pixel_address !== want.pixel_address) begin
                $error("pixel_address: expected %0h, actual %0h", want.pixel_address,
                       got.pixel_address);
                error_count++;
            end
            if (got.pixel_color !== want.pixel_color) begin
                $error("pixel_color: expected %0h, actual %0h", want.pixel_color,
                       got.pixel_color);
                error_count++;
            end
            if (got.last_pixel !== want.last_pixel) begin
                $error("last_pixel: expected %0b, actual %0b", want.last_pixel,
                       got.last_pixel);
                error_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   ready_hold = 0;
    int   cycle_count;

    pixel_predictor predictor = new();

    dlci_cfg_if cfg_if();
    dlci_req_if #(.COORD_BITS(COORD_BITS), .COLOR_BITS(COLOR_BITS)) req_if();
    dlci_rsp_if rsp_if();

    dda_line_color_interpolator_top #(
        .COORD_BITS(COORD_BITS),
        .COLOR_BITS(COLOR_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Clock: period 10
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: hold ready low in short random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else if (ready_hold != 0) begin
            rsp_if.ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 2);
        end
        else
            rsp_if.ready <= 1'b1;
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            predictor.check_pixel(pixel_t'{rsp_if.pixel_valid, rsp_if.pixel_address,
                                           rsp_if.pixel_color, rsp_if.last_pixel});
    end

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Present one request and wait for its transaction; valid stays high afterwards
    task automatic send_req(input line_req_t r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= r.action;
        req_if.start_x     <= r.start_x;
        req_if.start_y     <= r.start_y;
        req_if.start_color <= r.start_color;
        req_if.end_x       <= r.end_x;
        req_if.end_y       <= r.end_y;
        req_if.end_color   <= r.end_color;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predictor.note_request(r);
    endtask

    task automatic send_load(input int sx, input int sy, input color_t sc,
                             input int ex, input int ey, input color_t ec);
        line_req_t r;
        r.action      = ACTION_LOAD;
        r.start_x     = coord_t'(sx);
        r.start_y     = coord_t'(sy);
        r.start_color = sc;
        r.end_x       = coord_t'(ex);
        r.end_y       = coord_t'(ey);
        r.end_color   = ec;
        send_req(r);
    endtask

    // Step with random payload, which the block must ignore
    task automatic send_step();
        line_req_t r;
        r.action      = ACTION_STEP;
        r.start_x     = coord_t'($urandom);
        r.start_y     = coord_t'($urandom);
        r.start_color = color_t'($urandom);
        r.end_x       = coord_t'($urandom);
        r.end_y       = coord_t'($urandom);
        r.end_color   = color_t'($urandom);
        send_req(r);
    endtask

    // Drop valid, wait for every owed result, then let the block settle
    task automatic drain();
        req_if.valid <= 1'b0;
        while (predictor.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pitch(input pitch_t value);
        cfg_if.valid     <= 1'b1;
        cfg_if.row_pitch <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        predictor.row_pitch = value;
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly short edges walked to their end, some cut short or overrun
    task automatic random_run(input int count);
        int     sent;
        int     shape;
        int     reach;
        int     dx;
        int     dy;
        int     sx;
        int     sy;
        int     ex;
        int     ey;
        int     nsteps;
        color_t sc;
        color_t ec;
        sent = 0;
        while (sent < count) begin
            sx    = $urandom_range(0, COORD_MAX);
            sy    = $urandom_range(0, COORD_MAX);
            shape = $urandom_range(0, 9);
            if (shape < 8) begin
                reach = (shape == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
                dx = $urandom_range(0, reach);
                dy = $urandom_range(0, reach);
                if ($urandom_range(0, 1) == 1)
                    dx = reach;
                else
                    dy = reach;
                if ($urandom_range(0, 1) == 1)
                    dx = -dx;
                if ($urandom_range(0, 1) == 1)
                    dy = -dy;
                ex = (sx + dx < 0 || sx + dx > COORD_MAX) ? sx - dx : sx + dx;
                ey = (sy + dy < 0 || sy + dy > COORD_MAX) ? sy - dy : sy + dy;
            end
            else begin
                ex = $urandom_range(0, COORD_MAX);
                ey = $urandom_range(0, COORD_MAX);
            end
            sc = color_t'($urandom);
            ec = ($urandom_range(0, 4) == 0) ? sc : color_t'($urandom);
            send_load(sx, sy, sc, ex, ey, ec);
            sent++;

            dx     = (ex > sx) ? ex - sx : sx - ex;
            dy     = (ey > sy) ? ey - sy : sy - ey;
            reach  = (dx > dy) ? dx : dy;
            nsteps = (reach >= 2) ? reach - 1 : 0;
            // cut long edges short; the next load replaces them
            if (nsteps > 48 || $urandom_range(0, 7) == 0)
                nsteps = $urandom_range(0, (nsteps > 48) ? 6 : nsteps);
            // step past the end now and then
            if ($urandom_range(0, 3) == 0)
                nsteps += $urandom_range(1, 2);
            repeat (nsteps) begin
                send_step();
                sent++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        pitch_t pitches[6];
        pitches[0] = 13'd1;
        pitches[1] = 13'd8191;
        pitches[2] = 13'd0;
        pitches[3] = 13'd4096;
        pitches[4] = pitch_t'($urandom_range(2, 8190));
        pitches[5] = pitch_t'($urandom_range(1, 4096));

        idle_on            = 1'b1;
        rst_n              <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.row_pitch   <= '0;
        req_if.valid       <= 1'b0;
        req_if.action      <= ACTION_LOAD;
        req_if.start_x     <= '0;
        req_if.start_y     <= '0;
        req_if.start_color <= '0;
        req_if.end_x       <= '0;
        req_if.end_y       <= '0;
        req_if.end_color   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: step while idle, zero and unit length edges
        send_step();
        send_load(0, 0, 24'h000000, 0, 0, 24'h000000);
        send_step();
        send_load(5, 7, 24'h00ABCD, 6, 7, 24'hFF0000);
        send_step();
        // Full color swing with half-way rounding, run past the last pixel
        send_load(0, 0, 24'h000000, 4, 2, 24'hFFFFFF);
        repeat (4) send_step();
        // Longest edge, interrupted by a load with equal colors
        send_load(COORD_MAX, COORD_MAX, 24'hFFFFFF, 0, 0, 24'h000000);
        repeat (2) send_step();
        send_load(COORD_MAX, 0, 24'h123456, COORD_MAX - 3, 3, 24'h123456);
        repeat (2) send_step();
        send_load(0, COORD_MAX, 24'h000000, COORD_MAX, 0, 24'hFFFFFF);
        send_step();
        send_load(10, 10, 24'hFFFFFF, 10, 12, 24'h000000);
        send_step();
        random_run(PHASE_ITEMS / 2);
        drain();

        // Random phases, one row pitch each; the last one runs without idling
        for (int k = 0; k < 6; k++) begin
            if (k == 5) begin
                idle_on = 1'b0;
            end
            write_pitch(pitches[k]);
            random_run(PHASE_ITEMS);
            drain();
        end

        repeat (80) @(posedge clk);
        if (predictor.error_count == 0 && predictor.expected_pixels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
